// ===== sv/mrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI running status parser package
// Shared types and byte constants for the MIDI channel message parser.
// ----------------------------------------------------------------------------
package mrsp_pkg;

    localparam logic [7:0] IDLE_BYTE  = 8'hFF;
    localparam logic [6:0] ELEMENT_CC = 7'h53;
    localparam logic [1:0] ELEMENT_MAX = 2'd2;

    localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
    localparam logic [3:0] KIND_POLY_PRES = 4'hA;
    localparam logic [3:0] KIND_CTRL_CHG  = 4'hB;
    localparam logic [3:0] KIND_PROG_CHG  = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRES = 4'hD;
    localparam logic [3:0] KIND_PITCH     = 4'hE;

    localparam logic [1:0] CNT_EMPTY  = 2'd0;
    localparam logic [1:0] CNT_STATUS = 2'd1;
    localparam logic [1:0] CNT_DATA1  = 2'd2;
    localparam logic [1:0] CNT_DATA2  = 2'd3;

    typedef struct packed {
        logic [7:0] cur_status;
        logic [1:0] byte_count;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [7:0] running_status;
        logic [1:0] element;
    } t_state;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic       copy_to_usb;
        logic [1:0] element;
    } t_msg;

endpackage

// ===== sv/midi_running_status_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI running status parser
// Assembles channel messages from received MIDI bytes, with running status.
// ----------------------------------------------------------------------------
// The input channel carries one received byte and the scan flag per
// transaction; the byte 0xFF is an idle marker and changes nothing. The
// output channel carries one completed channel message per transaction,
// together with the USB copy flag and the current element number.
// Each byte is decoded in the cycle it is accepted, and a completed message
// appears on the output register in the next cycle. One byte can be taken in
// every cycle; the single output register sets that rate, since the input
// is held off only while a message waits there and the receiver stalls.
// Bytes that complete no message are accepted under the same rule.
// Reset clears the parser state, the running status, the element number
// and the output valid flag. A stalled message holds its value until taken.
// ----------------------------------------------------------------------------
module midi_running_status_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_scan_active,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_msg_status,
    output logic [6:0] o_msg_data1,
    output logic [6:0] o_msg_data2,
    output logic       o_copy_to_usb,
    output logic [1:0] o_element_number
);

    mrsp_pkg::t_state r_state;
    mrsp_pkg::t_state n_state;
    mrsp_pkg::t_msg   r_msg;
    mrsp_pkg::t_msg   n_msg;
    logic             r_out_valid;
    logic             emit;
    logic             in_take;

    mrsp_decode u_decode (
        .i_rx_byte    (i_rx_byte),
        .i_scan_active(i_scan_active),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_emit       (emit),
        .o_msg        (n_msg)
    );

    assign o_stall = r_out_valid & i_stall;
    assign in_take = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_state <= n_state;
            end
            if (in_take && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && emit) begin
            r_msg <= n_msg;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_msg_status     = r_msg.status;
    assign o_msg_data1      = r_msg.data1;
    assign o_msg_data2      = r_msg.data2;
    assign o_copy_to_usb    = r_msg.copy_to_usb;
    assign o_element_number = r_msg.element;

endmodule

// ===== sv/mrsp_decode.sv =====
// ----------------------------------------------------------------------------
// MIDI byte decoder
// Computes the next parser state and the completed message for one byte.
// ----------------------------------------------------------------------------
module mrsp_decode (
    input  logic [7:0]       i_rx_byte,
    input  logic             i_scan_active,
    input  mrsp_pkg::t_state i_state,
    output mrsp_pkg::t_state o_state,
    output logic             o_emit,
    output mrsp_pkg::t_msg   o_msg
);

    logic [7:0] cur;
    logic [1:0] cnt;
    logic [6:0] fd;
    logic [6:0] sd;
    logic [3:0] kind;
    logic       two_byte;
    logic       three_byte;

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        cur      = i_state.cur_status;
        cnt      = i_state.byte_count;
        fd       = i_state.first_data;
        sd       = i_state.second_data;
        kind     = 4'd0;
        two_byte = 1'b0;
        three_byte = 1'b0;
        o_msg.status      = 8'd0;
        o_msg.data1       = 7'd0;
        o_msg.data2       = 7'd0;
        o_msg.copy_to_usb = i_scan_active;
        o_msg.element     = i_state.element;

        if (i_rx_byte != mrsp_pkg::IDLE_BYTE) begin
            if (i_rx_byte[7]) begin
                o_state.cur_status = i_rx_byte;
                o_state.byte_count = mrsp_pkg::CNT_STATUS;
            end else begin
                if (cnt == mrsp_pkg::CNT_EMPTY) begin
                    cur = i_state.running_status;
                    cnt = mrsp_pkg::CNT_STATUS;
                end
                if (cnt == mrsp_pkg::CNT_STATUS) begin
                    fd  = i_rx_byte[6:0];
                    cnt = mrsp_pkg::CNT_DATA1;
                end else if (cnt == mrsp_pkg::CNT_DATA1) begin
                    sd  = i_rx_byte[6:0];
                    cnt = mrsp_pkg::CNT_DATA2;
                end
                kind = cur[7:4];
                two_byte = (kind == mrsp_pkg::KIND_PROG_CHG) ||
                           (kind == mrsp_pkg::KIND_CHAN_PRES);
                three_byte = (kind == mrsp_pkg::KIND_NOTE_OFF) ||
                             (kind == mrsp_pkg::KIND_NOTE_ON) ||
                             (kind == mrsp_pkg::KIND_POLY_PRES) ||
                             (kind == mrsp_pkg::KIND_CTRL_CHG) ||
                             (kind == mrsp_pkg::KIND_PITCH);

                o_state.cur_status  = cur;
                o_state.byte_count  = cnt;
                o_state.first_data  = fd;
                o_state.second_data = sd;
                o_msg.status = cur;
                o_msg.data1  = fd;

                if (cnt == mrsp_pkg::CNT_DATA1 && two_byte) begin
                    o_emit = 1'b1;
                    o_state.running_status = cur;
                    o_state.byte_count     = mrsp_pkg::CNT_EMPTY;
                end else if (cnt == mrsp_pkg::CNT_DATA2) begin
                    if (kind == mrsp_pkg::KIND_CTRL_CHG && fd == mrsp_pkg::ELEMENT_CC) begin
                        o_state.element = (sd == 7'd0) ? 2'd1 : mrsp_pkg::ELEMENT_MAX;
                        o_state.running_status = cur;
                        o_state.byte_count     = mrsp_pkg::CNT_EMPTY;
                    end else if (three_byte) begin
                        o_emit = 1'b1;
                        o_msg.data2 = sd;
                        o_state.running_status = cur;
                        o_state.byte_count     = mrsp_pkg::CNT_EMPTY;
                    end
                end
            end
        end
    end

endmodule
